[hdl/signed_log_pixel_map_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the signed log pixel map checker.
// ----------------------------------------------------------------------------
`ifndef SIGNED_LOG_PIXEL_MAP_ASSERT_SVH
`define SIGNED_LOG_PIXEL_MAP_ASSERT_SVH

// The consequent must hold once the delay n has passed after the antecedent.
`define SLPM_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("delayed check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SLPM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`endif

[hdl/slpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpm_pkg
// Shared widths, constants, the control struct and the mantissa table
// functions of the signed log pixel map.
// ----------------------------------------------------------------------------
package slpm_pkg;

   localparam int PIX_W                   = 32;
   localparam int LOG_W                   = 21;
   localparam int MAG_W                   = LOG_W - 1;
   localparam int FRAC_BITS_DEFAULT       = 16;
   localparam int TABLE_ADDR_BITS_DEFAULT = 8;

   // Table entries are log2 of the mantissa in Q30, plus one spare bit for 1.0.
   localparam int MANT_W = 31;
   localparam int EXP_W  = 5;
   // log2 of the magnitude with 30 fractional bits; the exponent stays below 32.
   localparam int L2_W   = 36;
   localparam int HALF_W = L2_W / 2;
   localparam int LN2_W  = 28;
   localparam int PP_W   = HALF_W + LN2_W;
   localparam int Q_W    = 64;

   // ln(2) in Q28.
   localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065279;
   localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

   // Cycles from an accepted request beat to its response beat.
   localparam int LATENCY = 10;

   typedef struct packed {
      logic valid;
      logic neg;
      logic zero;
   } ctl_type;

   // Position of the leading one; zero for an all-zero word.
   function automatic logic [EXP_W-1:0] lead_one(input logic [PIX_W-1:0] v);
      logic [EXP_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < PIX_W; i++) begin
         if (v[i]) begin
            pos = EXP_W'(i);
         end
      end
      return pos;
   endfunction

   // log2(1 + idx / 2^addr_bits) in Q30 by repeated squaring. It is only
   // called with constant arguments and folds to a constant at elaboration.
   function automatic logic [MANT_W-1:0] mant_entry(input int unsigned idx,
                                                    input int unsigned addr_bits);
      logic [63:0]       y;
      logic [MANT_W-1:0] res;
      int                k;
      res = '0;
      if (idx >= (32'd1 << addr_bits)) begin
         res = MANT_W'(1) << 30;
      end else begin
         y = (64'd1 << 30) + (64'(idx) << (30 - addr_bits));
         for (k = 0; k < 30; k++) begin
            y   = (y * y) >> 30;
            res = {res[MANT_W-2:0], 1'b0};
            if (y >= (64'd1 << 31)) begin
               y      = y >> 1;
               res[0] = 1'b1;
            end
         end
      end
      return res;
   endfunction

endpackage

[hdl/slpm_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpm_norm
// Magnitude, leading-one search and mantissa normalization in three stages.
// ----------------------------------------------------------------------------
module slpm_norm #(
   parameter int FRAC_BITS       = slpm_pkg::FRAC_BITS_DEFAULT,
   parameter int TABLE_ADDR_BITS = slpm_pkg::TABLE_ADDR_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [slpm_pkg::PIX_W-1:0]       in_pixel,
   output slpm_pkg::ctl_type                out_ctl,
   output logic [slpm_pkg::EXP_W-1:0]       out_exp,
   output logic [TABLE_ADDR_BITS-1:0]       out_idx,
   output logic [30-TABLE_ADDR_BITS:0]      out_rem
);
   import slpm_pkg::*;

   localparam int REM_W = 31 - TABLE_ADDR_BITS;

   // Stage 1: absolute value.
   logic             valid1_ff;
   logic             neg1_ff, neg1_in;
   logic [PIX_W-1:0] mag1_ff, mag1_in;

   // Stage 2: leading one and the below-one test.
   ctl_type          ctl2_ff, ctl2_in;
   logic [PIX_W-1:0] mag2_ff;
   logic [EXP_W-1:0] lead2_ff;

   // Stage 3: normalized mantissa split into table address and remainder.
   ctl_type          ctl3_ff;
   logic [EXP_W-1:0] exp3_ff, exp3_in;
   logic [PIX_W-1:0] shifted;
   logic [TABLE_ADDR_BITS-1:0] idx3_ff;
   logic [REM_W-1:0] rem3_ff;

   assign neg1_in = in_pixel[PIX_W-1];
   assign mag1_in = neg1_in ? (PIX_W'(0) - in_pixel) : in_pixel;

   always_comb begin
      ctl2_in.valid = valid1_ff;
      ctl2_in.neg   = neg1_ff;
      ctl2_in.zero  = ((mag1_ff >> FRAC_BITS) == '0);
   end

   assign shifted = mag2_ff << (EXP_W'(PIX_W - 1) - lead2_ff);
   assign exp3_in = lead2_ff - EXP_W'(FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         ctl2_ff   <= '0;
         ctl3_ff   <= '0;
      end else begin
         valid1_ff <= in_valid;
         ctl2_ff   <= ctl2_in;
         ctl3_ff   <= ctl2_ff;
      end
      neg1_ff  <= neg1_in;
      mag1_ff  <= mag1_in;
      mag2_ff  <= mag1_ff;
      lead2_ff <= lead_one(mag1_ff);
      exp3_ff  <= exp3_in;
      idx3_ff  <= shifted[PIX_W-2 -: TABLE_ADDR_BITS];
      rem3_ff  <= shifted[REM_W-1:0];
   end

   assign out_ctl = ctl3_ff;
   assign out_exp = exp3_ff;
   assign out_idx = idx3_ff;
   assign out_rem = rem3_ff;

endmodule

[hdl/slpm_log2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpm_log2
// Mantissa table lookup and linear interpolation into log2 in Q30.
// ----------------------------------------------------------------------------
module slpm_log2 #(
   parameter int TABLE_ADDR_BITS = slpm_pkg::TABLE_ADDR_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  slpm_pkg::ctl_type           in_ctl,
   input  logic [slpm_pkg::EXP_W-1:0]  in_exp,
   input  logic [TABLE_ADDR_BITS-1:0]  in_idx,
   input  logic [30-TABLE_ADDR_BITS:0] in_rem,
   output slpm_pkg::ctl_type           out_ctl,
   output logic [slpm_pkg::L2_W-1:0]   out_l2
);
   import slpm_pkg::*;

   localparam int REM_W   = 31 - TABLE_ADDR_BITS;
   localparam int ADDR_W  = TABLE_ADDR_BITS + 1;
   localparam int TBL_LEN = (1 << TABLE_ADDR_BITS) + 1;

   logic [MANT_W-1:0] mant_rom [TBL_LEN];

   for (genvar g = 0; g < TBL_LEN; g++) begin : g_rom
      localparam logic [MANT_W-1:0] ENTRY = mant_entry(g, TABLE_ADDR_BITS);
      assign mant_rom[g] = ENTRY;
   end

   logic [ADDR_W-1:0] lo_addr, hi_addr;
   logic [MANT_W-1:0] lo_val, hi_val, diff_full;

   ctl_type            ctl4_ff, ctl5_ff, ctl6_ff;
   logic [EXP_W-1:0]   exp4_ff, exp5_ff;
   logic [MANT_W-1:0]  lo4_ff, lo5_ff;
   logic [REM_W-1:0]   diff4_ff, rem4_ff;
   logic [2*REM_W-1:0] prod5_ff;
   logic [L2_W-1:0]    l2_6_ff, l2_6_in;

   assign lo_addr   = {1'b0, in_idx};
   assign hi_addr   = lo_addr + ADDR_W'(1);
   assign lo_val    = mant_rom[lo_addr];
   assign hi_val    = mant_rom[hi_addr];
   // Neighboring entries differ by less than 2^(31 - address bits).
   assign diff_full = hi_val - lo_val;

   assign l2_6_in = (L2_W'(exp5_ff) << 30) + L2_W'(lo5_ff)
                  + L2_W'(prod5_ff[2*REM_W-1:REM_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
         ctl5_ff <= '0;
         ctl6_ff <= '0;
      end else begin
         ctl4_ff <= in_ctl;
         ctl5_ff <= ctl4_ff;
         ctl6_ff <= ctl5_ff;
      end
      exp4_ff  <= in_exp;
      lo4_ff   <= lo_val;
      diff4_ff <= diff_full[REM_W-1:0];
      rem4_ff  <= in_rem;
      exp5_ff  <= exp4_ff;
      lo5_ff   <= lo4_ff;
      prod5_ff <= diff4_ff * rem4_ff;
      l2_6_ff  <= l2_6_in;
   end

   assign out_ctl = ctl6_ff;
   assign out_l2  = l2_6_ff;

endmodule

[hdl/slpm_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpm_scale
// Scaling by ln(2), rounding, saturation and sign restore.
// ----------------------------------------------------------------------------
module slpm_scale #(
   parameter int FRAC_BITS = slpm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  slpm_pkg::ctl_type                in_ctl,
   input  logic [slpm_pkg::L2_W-1:0]        in_l2,
   output logic                             out_valid,
   output logic signed [slpm_pkg::LOG_W-1:0] out_log
);
   import slpm_pkg::*;

   localparam int RND_SHIFT = 58 - FRAC_BITS;

   ctl_type          ctl7_ff, ctl8_ff, ctl9_ff;
   logic [PP_W-1:0]  pp_lo7_ff, pp_hi7_ff;
   logic [Q_W-1:0]   q8_ff, q8_in;
   logic [Q_W-1:0]   rnd_full;
   logic [MAG_W-1:0] mag9_ff, mag9_in;
   logic             valid10_ff;
   logic [LOG_W-1:0] log10_ff, log10_in;

   // The 36 by 28 bit product is taken as two 18 by 28 bit halves.
   assign q8_in = Q_W'(pp_lo7_ff) + (Q_W'(pp_hi7_ff) << HALF_W);

   assign rnd_full = (q8_ff + (Q_W'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
   assign mag9_in  = (rnd_full > Q_W'(MAG_MAX)) ? MAG_MAX : rnd_full[MAG_W-1:0];

   always_comb begin
      if (ctl9_ff.zero) begin
         log10_in = '0;
      end else if (ctl9_ff.neg) begin
         log10_in = LOG_W'(0) - {1'b0, mag9_ff};
      end else begin
         log10_in = {1'b0, mag9_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl7_ff    <= '0;
         ctl8_ff    <= '0;
         ctl9_ff    <= '0;
         valid10_ff <= 1'b0;
      end else begin
         ctl7_ff    <= in_ctl;
         ctl8_ff    <= ctl7_ff;
         ctl9_ff    <= ctl8_ff;
         valid10_ff <= ctl9_ff.valid;
      end
      pp_lo7_ff <= PP_W'(in_l2[HALF_W-1:0]) * PP_W'(LN2_Q28);
      pp_hi7_ff <= PP_W'(in_l2[L2_W-1:HALF_W]) * PP_W'(LN2_Q28);
      q8_ff     <= q8_in;
      mag9_ff   <= mag9_in;
      log10_ff  <= log10_in;
   end

   assign out_valid = valid10_ff;
   assign out_log   = $signed(log10_ff);

endmodule

[hdl/signed_log_pixel_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_log_pixel_map
// Sign-preserving natural logarithm of a signed fixed-point pixel, streamed
// one pixel per clock through a ten-stage pipeline.
// ----------------------------------------------------------------------------
//
// Channel    Ports                        Handshake
// ---------  ---------------------------  -------------------------------------
// request    start, busy, req_pixel_value beat taken when start high, busy low
// response   rsp_valid, rsp_log_value     one-cycle strobe, always taken
//
// A request beat produces its response beat at the end of the pipeline, and a
// new beat can enter on every clock, so throughput is one pixel per cycle.
// The stages hold the table read with interpolation multiply and the
// ln(2) scaling multiply, which is split into two halves over two stages.
// Reset is synchronous and clears only the control bits (valid, sign, zero).
// The receiver cannot stall, so the pipeline never holds and busy stays low.
//
// Values of magnitude below one map to zero. Otherwise log2 of the magnitude
// is the leading-one position minus the fraction width, plus a table value
// for the mantissa interpolated linearly between neighboring entries. That
// log2 is multiplied by ln(2), rounded half up to the output fraction,
// saturated to the 20-bit magnitude range and given the pixel's sign.
// ----------------------------------------------------------------------------
module signed_log_pixel_map #(
   parameter int FRAC_BITS       = slpm_pkg::FRAC_BITS_DEFAULT,
   parameter int TABLE_ADDR_BITS = slpm_pkg::TABLE_ADDR_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [slpm_pkg::PIX_W-1:0] req_pixel_value,
   output logic                              rsp_valid,
   output logic signed [slpm_pkg::LOG_W-1:0] rsp_log_value
);
   import slpm_pkg::*;

   // Control and payload between the three sections of the pipeline.
   ctl_type                     norm_ctl;
   logic [EXP_W-1:0]            norm_exp;
   logic [TABLE_ADDR_BITS-1:0]  norm_idx;
   logic [30-TABLE_ADDR_BITS:0] norm_rem;
   ctl_type                     log2_ctl;
   logic [L2_W-1:0]             log2_val;
   logic                        accept;

   // Every stage advances on every clock, so the block is never busy.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Stages one to three: magnitude, leading one, normalized mantissa.
   slpm_norm #(
      .FRAC_BITS       (FRAC_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_norm (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_pixel ($unsigned(req_pixel_value)),
      .out_ctl  (norm_ctl),
      .out_exp  (norm_exp),
      .out_idx  (norm_idx),
      .out_rem  (norm_rem)
   );

   // Stages four to six: table read, interpolation product, log2 sum.
   slpm_log2 #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_log2 (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (norm_ctl),
      .in_exp  (norm_exp),
      .in_idx  (norm_idx),
      .in_rem  (norm_rem),
      .out_ctl (log2_ctl),
      .out_l2  (log2_val)
   );

   // Stages seven to ten: ln(2) scaling, rounding, saturation and sign.
   slpm_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (log2_ctl),
      .in_l2     (log2_val),
      .out_valid (rsp_valid),
      .out_log   (rsp_log_value)
   );

endmodule

[hdl/slpm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpm_checker
// Port-level checks of beat timing and result sign for the pixel log map.
// ----------------------------------------------------------------------------
`include "signed_log_pixel_map_assert.svh"

module slpm_checker #(
   parameter int FRAC_BITS = slpm_pkg::FRAC_BITS_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic signed [slpm_pkg::PIX_W-1:0] req_pixel_value,
   input logic                              rsp_valid,
   input logic signed [slpm_pkg::LOG_W-1:0] rsp_log_value
);
   import slpm_pkg::*;

   localparam int ONE_VAL = 1 << FRAC_BITS;

   logic accept;
   logic below_one, pos_pixel, neg_pixel;

   assign accept    = start && !busy;
   assign below_one = (req_pixel_value < ONE_VAL) && (req_pixel_value > -ONE_VAL);
   assign pos_pixel = (req_pixel_value >= ONE_VAL);
   assign neg_pixel = (req_pixel_value <= -ONE_VAL);

   // Every accepted beat comes back exactly after the pipeline latency.
   `SLPM_ASSERT_DELAY(a_rsp_follows, clock, reset, accept, LATENCY, rsp_valid)

   // No response beat appears without a request beat that caused it.
   `SLPM_ASSERT_IMPLY(a_rsp_caused, clock, reset, rsp_valid, $past(accept, LATENCY))

   // Magnitudes below one give a zero result.
   `SLPM_ASSERT_DELAY(a_zero_small, clock, reset, accept && below_one, LATENCY,
      rsp_log_value == '0)

   // The result keeps the sign of the pixel or is zero.
   `SLPM_ASSERT_DELAY(a_sign_pos, clock, reset, accept && pos_pixel, LATENCY,
      !rsp_log_value[LOG_W-1])
   `SLPM_ASSERT_DELAY(a_sign_neg, clock, reset, accept && neg_pixel, LATENCY,
      rsp_log_value[LOG_W-1] || rsp_log_value == '0)

endmodule

bind signed_log_pixel_map slpm_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_pixel_value (req_pixel_value),
   .rsp_valid       (rsp_valid),
   .rsp_log_value   (rsp_log_value)
);
